// File: hdl/gpf_pkg.sv
// Grid peak finder: shared constants, field widths and the queue entry type.
// Used by every module of the peak finder but gpf_ram; depends on nothing.
`default_nettype none

package gpf_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int SAMPLE_BITS = 32;

	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int DIM_W       = 11;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_FIELD_W = 10;
	localparam int OUT_DATA_W  = 24;
	localparam int CFG_IDX_W   = 8;
	localparam int DIM_RESET   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	localparam logic [SAMPLE_BITS-1:0] KEY_SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// peak kinds, in release order
	localparam int PK_ABOVE = 0;
	localparam int PK_LEFT  = 1;
	localparam int PK_OWN   = 2;
	localparam int PK_NUM   = 3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [PK_NUM-1:0] mask;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} gpf_entry_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		begin
			if (v == '0) begin
				r = DIM_W'(1);
			end else if (v > hi) begin
				r = hi;
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/gpf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`default_nettype none

module gpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/gpf_front.sv
// Front end: config registers, raster counters, line buffers and the peak tests.
// Pushes one entry per sample with at least one peak. Uses gpf_pkg and gpf_ram.
`default_nettype none

module gpf_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [gpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gpf_pkg::DIM_W-1:0]       cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [gpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  wire logic [gpf_pkg::QCNT_W-1:0]      q_count,
	output logic                                 push,
	output gpf_pkg::gpf_entry_t                  push_entry
);

	localparam int KW = gpf_pkg::SAMPLE_BITS;
	localparam int RW = gpf_pkg::ROW_W;
	localparam int CW = gpf_pkg::COL_W;
	localparam int DW = gpf_pkg::DIM_W;

	logic [DW-1:0] num_rows_q, num_cols_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          accept, restart, last_row, last_col;
	logic [KW-1:0] key;

	// stage 1: sample whose line-buffer reads are in flight
	logic          valid_s1, last_row_s1, last_col_s1, byp_s1;
	logic [KW-1:0] key_s1, byp_data_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	logic [KW-1:0] left_q, left_left_q, above_left_q;
	logic [KW-1:0] pa_rd, pb_rd, older_rd, older_v;
	logic [CW-1:0] col_next;
	logic          r_ge1, r_ge2, c_ge1, c_ge2;
	logic          ok_above, ok_left, ok_own;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && ((cfg_index == gpf_pkg::REG_NUM_ROWS) ||
		(cfg_index == gpf_pkg::REG_NUM_COLS));

	// room in the queue for this sample and the one in stage 1
	assign s_axis_tready = (gpf_pkg::QCNT_W'(q_count + gpf_pkg::QCNT_W'(valid_s1)) <
		gpf_pkg::QCNT_W'(gpf_pkg::QDEPTH));
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign key      = s_axis_tdata[KW-1:0] ^ gpf_pkg::KEY_SIGN;
	assign last_row = (DW'(row_q) + DW'(1)) >= num_rows_q;
	assign last_col = (DW'(col_q) + DW'(1)) >= num_cols_q;
	assign col_next = CW'(col_q + CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DW'(gpf_pkg::DIM_RESET);
			num_cols_q <= DW'(gpf_pkg::DIM_RESET);
		end else if (cfg_valid) begin
			if (cfg_index == gpf_pkg::REG_NUM_ROWS) begin
				num_rows_q <= gpf_pkg::clamp_dim(cfg_data, DW'(gpf_pkg::MAX_ROWS));
			end
			if (cfg_index == gpf_pkg::REG_NUM_COLS) begin
				num_cols_q <= gpf_pkg::clamp_dim(cfg_data, DW'(gpf_pkg::MAX_COLS));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : RW'(row_q + RW'(1));
			end else begin
				col_q <= col_next;
			end
		end
	end

	// prev row held twice so column c and c+1 come out together
	gpf_ram #(.WIDTH(KW), .DEPTH(gpf_pkg::MAX_COLS)) u_prev_a (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (key),
		.raddr (col_q),
		.rdata (pa_rd)
	);

	gpf_ram #(.WIDTH(KW), .DEPTH(gpf_pkg::MAX_COLS)) u_prev_b (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (key),
		.raddr (col_next),
		.rdata (pb_rd)
	);

	// older row takes the displaced prev-row value in the cycle after the prev-row write
	gpf_ram #(.WIDTH(KW), .DEPTH(gpf_pkg::MAX_COLS)) u_older (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (pa_rd),
		.raddr (col_q),
		.rdata (older_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1      <= key;
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
			// one-column grid: older entry is being written in this very cycle
			byp_s1      <= valid_s1 && (col_s1 == col_q);
			byp_data_s1 <= pa_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			left_left_q  <= '0;
			above_left_q <= '0;
		end else if (valid_s1) begin
			left_left_q  <= left_q;
			left_q       <= key_s1;
			above_left_q <= pa_rd;
		end
	end

	assign older_v = byp_s1 ? byp_data_s1 : older_rd;
	assign r_ge1   = (row_s1 != '0);
	assign r_ge2   = (row_s1 > RW'(1));
	assign c_ge1   = (col_s1 != '0);
	assign c_ge2   = (col_s1 > CW'(1));

	always_comb begin
		ok_above = r_ge1 && (pa_rd >= key_s1);
		if (r_ge2 && (pa_rd < older_v)) begin
			ok_above = 1'b0;
		end
		if (c_ge1 && (pa_rd < above_left_q)) begin
			ok_above = 1'b0;
		end
		if (!last_col_s1 && (pa_rd < pb_rd)) begin
			ok_above = 1'b0;
		end

		ok_left = last_row_s1 && c_ge1 && (left_q >= key_s1);
		if (c_ge2 && (left_q < left_left_q)) begin
			ok_left = 1'b0;
		end
		if (r_ge1 && (left_q < above_left_q)) begin
			ok_left = 1'b0;
		end

		ok_own = last_row_s1 && last_col_s1;
		if (c_ge1 && (key_s1 < left_q)) begin
			ok_own = 1'b0;
		end
		if (r_ge1 && (key_s1 < pa_rd)) begin
			ok_own = 1'b0;
		end
	end

	always_comb begin
		push_entry                        = '0;
		push_entry.mask[gpf_pkg::PK_ABOVE] = ok_above;
		push_entry.mask[gpf_pkg::PK_LEFT]  = ok_left;
		push_entry.mask[gpf_pkg::PK_OWN]   = ok_own;
		push_entry.row                    = row_s1;
		push_entry.col                    = col_s1;
	end

	assign push = valid_s1 && (ok_above || ok_left || ok_own);

endmodule

`default_nettype wire

// File: hdl/gpf_fifo.sv
// Short register queue of peak entries between the front end and the output.
// Uses gpf_pkg for the entry type and depth.
`default_nettype none

module gpf_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire gpf_pkg::gpf_entry_t         push_entry,
	input  wire logic                        pop,
	output gpf_pkg::gpf_entry_t              head,
	output logic                             head_valid,
	output logic [gpf_pkg::QCNT_W-1:0]       count
);

	gpf_pkg::gpf_entry_t              mem_q [gpf_pkg::QDEPTH];
	logic [gpf_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [gpf_pkg::QCNT_W-1:0]       count_q;
	logic                             do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= gpf_pkg::QPTR_W'(wr_ptr_q + gpf_pkg::QPTR_W'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= gpf_pkg::QPTR_W'(rd_ptr_q + gpf_pkg::QPTR_W'(1));
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= gpf_pkg::QCNT_W'(count_q + gpf_pkg::QCNT_W'(1));
				2'b01:   count_q <= gpf_pkg::QCNT_W'(count_q - gpf_pkg::QCNT_W'(1));
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/gpf_back.sv
// Back end: walks the peak mask of the queue head and sends one peak per transfer,
// tlast on the last peak of a sample. Uses gpf_pkg.
`default_nettype none

module gpf_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gpf_pkg::gpf_entry_t              head,
	input  wire logic                             head_valid,
	output logic                                  pop,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [gpf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	output logic                                  m_axis_tlast
);

	localparam int OW = gpf_pkg::OUT_FIELD_W;

	logic [gpf_pkg::PK_NUM-1:0] done_q, rem, sel, rest;
	logic [OW-1:0]              peak_row, peak_col;
	logic                       xfer;

	assign rem = head.mask & ~done_q;

	always_comb begin
		sel = '0;
		priority if (rem[gpf_pkg::PK_ABOVE]) begin
			sel[gpf_pkg::PK_ABOVE] = 1'b1;
		end else if (rem[gpf_pkg::PK_LEFT]) begin
			sel[gpf_pkg::PK_LEFT] = 1'b1;
		end else begin
			sel[gpf_pkg::PK_OWN] = 1'b1;
		end
	end

	assign rest = rem & ~sel;

	always_comb begin
		peak_row = OW'(head.row);
		peak_col = OW'(head.col);
		if (sel[gpf_pkg::PK_ABOVE]) begin
			peak_row = OW'(head.row - gpf_pkg::ROW_W'(1));
		end
		if (sel[gpf_pkg::PK_LEFT]) begin
			peak_col = OW'(head.col - gpf_pkg::COL_W'(1));
		end
	end

	assign m_axis_tvalid = head_valid;
	assign m_axis_tlast  = (rest == '0);
	assign m_axis_tdata  = gpf_pkg::OUT_DATA_W'({peak_col, peak_row});
	assign xfer          = m_axis_tvalid && m_axis_tready;
	assign pop           = xfer && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (xfer) begin
			done_q <= m_axis_tlast ? '0 : (done_q | sel);
		end
	end

endmodule

`default_nettype wire

// File: hdl/grid_peak_finder_unit.sv
// Grid peak finder, 4-neighbour local maxima over a raster stream of samples.
// A peak passes the stage-1 registers and the queue before it appears on m_axis.
// Throughput: one sample per cycle while the queue has room; a sample releasing k peaks sends k transfers,
// the four-entry queue absorbing bursts. Line-buffer read data arrives in the cycle after accept.
// Reset: counters zero, both dimensions 16; line buffers are not cleared.
`default_nettype none

module grid_peak_finder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gpf_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [gpf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] sample
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [gpf_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // [9:0] peak_row, [19:10] peak_col
	output logic                                   m_axis_tlast   // last_of_run
);

	gpf_pkg::gpf_entry_t              push_entry, head;
	logic                             push, pop, head_valid;
	logic [gpf_pkg::QCNT_W-1:0]       q_count;

	gpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_count       (q_count),
		.push          (push),
		.push_entry    (push_entry)
	);

	gpf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	gpf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: sim/peak_list_checker.sv
// Checker for the grid peak finder: follows the register writes and the sample stream,
// predicts the peak list of every accepted sample and compares it with the result stream.
// Depends on gpf_pkg for widths, limits and register indexes.

module peak_list_checker
	import gpf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DIM_W-1:0]       cfg_data,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_DATA_W-1:0]   s_tdata,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_DATA_W-1:0]  m_tdata,
	input  wire logic                   m_tlast,
	output int                          fail_count,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_FIELD_W-1:0] row;
		logic [OUT_FIELD_W-1:0] col;
		logic                   last;
	} peak_t;

	// line_two_up holds the row two above, except left of the current column,
	// where it has already been overwritten with the row just above
	logic signed [SAMPLE_BITS-1:0] line_above  [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] line_two_up [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] left_one;
	logic signed [SAMPLE_BITS-1:0] left_two;
	int grid_rows;
	int grid_cols;
	int cur_row;
	int cur_col;
	int errs;
	peak_t peaks_due [$];

	function automatic int clamp_extent(input logic [DIM_W-1:0] v, input int hi);
		if (v == '0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic peak_t make_peak(input int r, input int c);
		peak_t p;
		p.row  = r[OUT_FIELD_W-1:0];
		p.col  = c[OUT_FIELD_W-1:0];
		p.last = 1'b0;
		return p;
	endfunction

	task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		if (idx == REG_NUM_ROWS) begin
			grid_rows = clamp_extent(val, MAX_ROWS);
		end else if (idx == REG_NUM_COLS) begin
			grid_cols = clamp_extent(val, MAX_COLS);
		end else begin
			return;
		end
		cur_row = 0;
		cur_col = 0;
	endtask

	// decides the cell above, the cell to the left on the last row, and the
	// final cell of the grid, in that order
	task automatic predict_sample(input logic signed [SAMPLE_BITS-1:0] s);
		peak_t found [3];
		int n;
		bit on_last_row;
		bit on_last_col;
		bit ok;
		logic signed [SAMPLE_BITS-1:0] mid;
		n = 0;
		on_last_row = (cur_row + 1 >= grid_rows);
		on_last_col = (cur_col + 1 >= grid_cols);
		if (cur_row >= 1) begin
			mid = line_above[cur_col];
			ok = (mid >= s);
			if (cur_row >= 2 && mid < line_two_up[cur_col])
				ok = 1'b0;
			if (cur_col >= 1 && mid < line_two_up[cur_col-1])
				ok = 1'b0;
			if (!on_last_col && mid < line_above[cur_col+1])
				ok = 1'b0;
			if (ok) begin
				found[n] = make_peak(cur_row - 1, cur_col);
				n++;
			end
		end
		if (on_last_row && cur_col >= 1) begin
			mid = left_one;
			ok = (mid >= s);
			if (cur_col >= 2 && mid < left_two)
				ok = 1'b0;
			if (cur_row >= 1 && mid < line_two_up[cur_col-1])
				ok = 1'b0;
			if (ok) begin
				found[n] = make_peak(cur_row, cur_col - 1);
				n++;
			end
		end
		if (on_last_row && on_last_col) begin
			ok = 1'b1;
			if (cur_col >= 1 && s < left_one)
				ok = 1'b0;
			if (cur_row >= 1 && s < line_above[cur_col])
				ok = 1'b0;
			if (ok) begin
				found[n] = make_peak(cur_row, cur_col);
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			peaks_due.push_back(found[i]);
		end

		line_two_up[cur_col] = line_above[cur_col];
		line_above[cur_col]  = s;
		left_two = left_one;
		left_one = s;
		if (on_last_col) begin
			cur_col = 0;
			cur_row = on_last_row ? 0 : cur_row + 1;
		end else begin
			cur_col++;
		end
	endtask

	task automatic check_peak(input logic [OUT_DATA_W-1:0] data, input logic tl);
		peak_t want;
		logic [OUT_FIELD_W-1:0] got_row;
		logic [OUT_FIELD_W-1:0] got_col;
		logic [OUT_DATA_W-2*OUT_FIELD_W-1:0] got_pad;
		got_row = data[OUT_FIELD_W-1:0];
		got_col = data[2*OUT_FIELD_W-1:OUT_FIELD_W];
		got_pad = data[OUT_DATA_W-1:2*OUT_FIELD_W];
		if (peaks_due.size() == 0) begin
			errs++;
			if (errs <= 10)
				$display("%t: unexpected peak row %0d col %0d last %0b", $realtime,
					got_row, got_col, tl);
		end else begin
			want = peaks_due.pop_front();
			if (got_row !== want.row || got_col !== want.col || tl !== want.last
					|| got_pad !== '0) begin
				errs++;
				if (errs <= 10)
					$display("%t: peak mismatch, expected row %0d col %0d last %0b, got row %0d col %0d last %0b pad %0h",
						$realtime, want.row, want.col, want.last, got_row, got_col, tl, got_pad);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows = DIM_RESET;
			grid_cols = DIM_RESET;
			cur_row = 0;
			cur_col = 0;
			left_one = '0;
			left_two = '0;
			errs = 0;
			peaks_due.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				predict_sample($signed(s_tdata[SAMPLE_BITS-1:0]));
			if (m_tvalid && m_tready)
				check_peak(m_tdata, m_tlast);
			fail_count  <= errs;
			outstanding <= peaks_due.size();
		end
	end

endmodule

// File: sim/grid_peak_finder_unit_test.sv
// Top of the grid peak finder test: clock, reset, register writes, sample stream and
// output back-pressure; checking is done by peak_list_checker beside the block.
// Depends on gpf_pkg, grid_peak_finder_unit and peak_list_checker.

module grid_peak_finder_unit_test;
	import gpf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 240;
	localparam int SINK_HOLD    = 400;
	localparam int SETTLE       = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	bit sender_steady = 1'b0;
	bit sink_hold_req = 1'b0;
	bit sink_hold_done = 1'b0;
	int sink_stall = 0;
	int sink_run = 0;

	grid_peak_finder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	peak_list_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tlast(m_axis_tlast),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("grid_peak_finder_unit_test: errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// plenty of small values so that ties and plateaus occur
	function automatic logic [IN_DATA_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4: return $urandom;
			default: return IN_DATA_W'($urandom_range(0, 6)) - IN_DATA_W'(3);
		endcase
	endfunction

	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return 1;
			1: return $urandom_range(9, 32);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	// result side: random stalls, long ready stretches, one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
			sink_run = 0;
		end else begin
			if (sink_hold_req && !sink_hold_done) begin
				sink_hold_done = 1'b1;
				sink_stall = SINK_HOLD;
				sink_run = 0;
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else if (sink_run > 0) begin
				sink_run--;
				m_axis_tready <= 1'b1;
			end else begin
				sink_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 16);
				sink_stall = pick_gap();
				if (sink_stall > 0) begin
					sink_stall--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	task automatic push_sample(input logic [IN_DATA_W-1:0] value);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// stop sending, let every predicted peak drain, then allow for samples still in flight
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no toggle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_grid(input int rows, input int cols);
		wait_idle();
		cfg_write(REG_NUM_ROWS, rows[DIM_W-1:0]);
		cfg_write(REG_NUM_COLS, cols[DIM_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int rows;
		int cols;
		int count;
		int random_items;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, extremes of the sample range
		push_sample(32'h8000_0000);
		push_sample(32'h7fff_ffff);
		push_sample(32'h0000_0000);
		push_sample(32'hffff_ffff);

		// zero rows acts as one: single-row grid, wraps twice
		set_grid(0, 3);
		push_sample(32'h8000_0000);
		push_sample(32'h7fff_ffff);
		push_sample(32'h7fff_ffff);
		push_sample(32'h0000_0000);
		push_sample(32'hffff_ffff);
		push_sample(32'h0000_0000);

		// zero columns acts as one: single-column grid
		set_grid(3, 0);
		push_sample(32'd5);
		push_sample(32'd5);
		push_sample(32'd7);
		push_sample(32'd7);

		// plateau; a write to a spare index mid-grid must not restart it
		set_grid(2, 2);
		push_sample(32'd1);
		push_sample(32'd1);
		push_sample(32'd1);
		wait_idle();
		cfg_write(REG_SPARE_TOP, '1);
		cfg_valid <= 1'b0;
		push_sample(32'd1);
		push_sample(32'h7fff_ffff);
		push_sample(32'h8000_0000);

		// flat single row: a peak per sample, output held off so the input stalls
		set_grid(1, 8);
		sink_hold_req <= 1'b1;
		sender_steady = 1'b1;
		repeat (40) push_sample(32'h0000_0042);
		sender_steady = 1'b0;

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			rows = pick_extent();
			cols = pick_extent();
			count = rows * cols * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(1, cols);
			if (count > 90)
				count = $urandom_range(30, 90);
			sender_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0) begin
				// rows left as they were; spare index in between
				wait_idle();
				cfg_write(CFG_IDX_W'($urandom_range(2, 254)), DIM_W'($urandom));
				cfg_write(REG_NUM_COLS, cols[DIM_W-1:0]);
				cfg_valid <= 1'b0;
			end else begin
				set_grid(rows, cols);
			end
			repeat (count) push_sample(rand_sample());
			random_items += count;
		end

		// largest sizes: all-ones extents clamp to the maximum
		sender_steady = 1'b0;
		set_grid(2047, 1);
		repeat (60) push_sample(rand_sample());
		set_grid(1, 2047);
		repeat (60) push_sample(rand_sample());
		set_grid(MAX_ROWS, MAX_COLS);
		repeat (60) push_sample(rand_sample());

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("grid_peak_finder_unit_test: clean");
		end else begin
			$display("grid_peak_finder_unit_test: errors");
		end
		$finish;
	end

endmodule
